[hw/rtl/strip_rect_fill_compositor_macros.svh]
// Assertion helpers for the compositor RTL, used by srfc_back.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef STRIP_RECT_FILL_COMPOSITOR_MACROS_SVH
`define STRIP_RECT_FILL_COMPOSITOR_MACROS_SVH

// same-cycle implication
`define SRFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srfc: same-cycle check failed");

// next-cycle implication
`define SRFC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srfc: next-cycle check failed");

`endif

[hw/rtl/srfc_pkg.sv]
package srfc_pkg;

    // opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // result kinds
    localparam logic [1:0] RES_NONE   = 2'd0;
    localparam logic [1:0] RES_DIRECT = 2'd1;
    localparam logic [1:0] RES_STRIP  = 2'd2;
    localparam logic [1:0] RES_PIXEL  = 2'd3;

    // config register indexes
    localparam logic [2:0] CFG_REGION_LEFT     = 3'd0;
    localparam logic [2:0] CFG_REGION_COLUMNS  = 3'd1;
    localparam logic [2:0] CFG_STRIP_FIRST_ROW = 3'd2;
    localparam logic [2:0] CFG_STRIP_ROW_COUNT = 3'd3;
    localparam logic [2:0] CFG_COMPOSE_MODE    = 3'd4;

    // strip offsets: base + column stays below 2^14 for any register values
    localparam int IDX_W = 16;

    // job queue between front and back
    localparam int Q_PTR_W   = 1;
    localparam int Q_DEPTH   = 2 ** Q_PTR_W;
    localparam int Q_COUNT_W = Q_PTR_W + 1;

    typedef enum logic [1:0] {
        JOB_EMIT,
        JOB_WRITE,
        JOB_READ
    } t_job_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WRITE,
        BK_READ,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [8:0]  x;
        logic [7:0]  y;
        logic [8:0]  width;
        logic [7:0]  height;
        logic [15:0] color;
    } t_result;

    typedef struct packed {
        t_job_kind        kind;
        t_result          res;
        logic [15:0]      color;
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] col_start;
        logic [IDX_W-1:0] col_end;
        logic [4:0]       rows;
        logic [8:0]       pitch;
        logic [12:0]      pix;
    } t_job;

endpackage

[hw/rtl/srfc_ram.sv]
module srfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 5120,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/srfc_front.sv]
module srfc_front #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int DEPTH         = 5120
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [15:0] i_rect_x,
    input  logic signed [15:0] i_rect_y,
    input  logic signed [15:0] i_rect_width,
    input  logic signed [15:0] i_rect_height,
    input  logic [15:0]        i_fill_color,
    input  logic [12:0]        i_pixel_index,
    input  logic               i_q_full,
    output logic               o_push,
    output srfc_pkg::t_job     o_job
);
    import srfc_pkg::*;

    localparam logic signed [17:0] SW_S = 18'(SCREEN_WIDTH);
    localparam logic signed [17:0] SH_S = 18'(SCREEN_HEIGHT);

    logic [8:0] r_region_left;
    logic [8:0] r_region_columns;
    logic [7:0] r_strip_first_row;
    logic [4:0] r_strip_row_count;
    logic       r_compose_mode;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_left     <= 9'd0;
            r_region_columns  <= 9'd320;
            r_strip_first_row <= 8'd0;
            r_strip_row_count <= 5'd16;
            r_compose_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REGION_LEFT:     r_region_left     <= i_cfg_data;
                CFG_REGION_COLUMNS:  r_region_columns  <= i_cfg_data;
                CFG_STRIP_FIRST_ROW: r_strip_first_row <= i_cfg_data[7:0];
                CFG_STRIP_ROW_COUNT: r_strip_row_count <= i_cfg_data[4:0];
                CFG_COMPOSE_MODE:    r_compose_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake: an item goes straight into the queue
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // rectangle edges at full precision
    logic signed [17:0] sx, sy, sw, sh, x_end, y_end;
    logic signed [17:0] dx0, dx1, dy0, dy1;
    logic signed [17:0] left_s, right_s, top_s, bot_s;
    logic signed [17:0] cx0, cx1, cy0, cy1;
    logic signed [17:0] dw, dh, c_ro, c_rows, c_cs, c_ce;
    logic               positive, direct_hit, compose_hit;
    logic [13:0]        base_prod, clear_prod;
    logic [IDX_W-1:0]   clear_len;

    assign sx    = 18'(i_rect_x);
    assign sy    = 18'(i_rect_y);
    assign sw    = 18'(i_rect_width);
    assign sh    = 18'(i_rect_height);
    assign x_end = sx + sw;
    assign y_end = sy + sh;

    assign positive = (i_rect_width > 16'sd0) && (i_rect_height > 16'sd0);

    // screen clip
    assign dx0 = (sx < 18'sd0) ? 18'sd0 : sx;
    assign dx1 = (x_end > SW_S) ? SW_S : x_end;
    assign dy0 = (sy < 18'sd0) ? 18'sd0 : sy;
    assign dy1 = (y_end > SH_S) ? SH_S : y_end;
    assign dw  = dx1 - dx0;
    assign dh  = dy1 - dy0;
    assign direct_hit = positive && (dx1 > dx0) && (dy1 > dy0);

    // strip and region clip, on top of the screen column clip
    assign left_s  = 18'({9'd0, r_region_left});
    assign right_s = left_s + 18'({9'd0, r_region_columns});
    assign top_s   = 18'({10'd0, r_strip_first_row});
    assign bot_s   = top_s + 18'({13'd0, r_strip_row_count});
    assign cx0 = (dx0 < left_s) ? left_s : dx0;
    assign cx1 = (dx1 > right_s) ? right_s : dx1;
    assign cy0 = (sy < top_s) ? top_s : sy;
    assign cy1 = (y_end > bot_s) ? bot_s : y_end;
    assign compose_hit = positive && (cx1 > cx0) && (cy1 > cy0);

    assign c_ro   = cy0 - top_s;
    assign c_rows = cy1 - cy0;
    assign c_cs   = cx0 - left_s;
    assign c_ce   = cx1 - left_s;

    // strip row base and clear length
    assign base_prod  = {9'd0, c_ro[4:0]} * {5'd0, r_region_columns};
    assign clear_prod = {9'd0, r_strip_row_count} * {5'd0, r_region_columns};
    assign clear_len  = (32'(clear_prod) > 32'(DEPTH)) ? IDX_W'(DEPTH) : IDX_W'(clear_prod);

    // classify the item into a job
    always_comb begin
        o_job           = '0;
        o_job.kind      = JOB_EMIT;
        o_job.res.kind  = RES_NONE;
        o_job.color     = i_fill_color;
        o_job.pitch     = r_region_columns;
        o_job.pix       = i_pixel_index;
        case (i_opcode)
            OP_CLEAR: begin
                o_job.res.kind = RES_STRIP;
                o_job.rows     = 5'd1;
                o_job.col_end  = clear_len;
                if (clear_len != '0) begin
                    o_job.kind = JOB_WRITE;
                end
            end
            OP_READ: begin
                o_job.res.kind = RES_PIXEL;
                if (32'(i_pixel_index) < 32'(DEPTH)) begin
                    o_job.kind = JOB_READ;
                end
            end
            OP_FILL: begin
                if (!r_compose_mode) begin
                    if (direct_hit) begin
                        o_job.res.kind   = RES_DIRECT;
                        o_job.res.x      = dx0[8:0];
                        o_job.res.y      = dy0[7:0];
                        o_job.res.width  = dw[8:0];
                        o_job.res.height = dh[7:0];
                        o_job.res.color  = i_fill_color;
                    end
                end else if (compose_hit) begin
                    o_job.kind      = JOB_WRITE;
                    o_job.res.kind  = RES_STRIP;
                    o_job.base      = IDX_W'(base_prod);
                    o_job.col_start = c_cs[IDX_W-1:0];
                    o_job.col_end   = c_ce[IDX_W-1:0];
                    o_job.rows      = c_rows[4:0];
                end
            end
            default: ;
        endcase
    end

endmodule

[hw/rtl/srfc_queue.sv]
module srfc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srfc_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output srfc_pkg::t_job o_job
);
    import srfc_pkg::*;

    t_job                 r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_COUNT_W-1:0] r_count;
    logic                 do_push, do_pop;

    assign o_full  = (r_count == Q_COUNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule

[hw/rtl/srfc_back.sv]
`include "strip_rect_fill_compositor_macros.svh"

module srfc_back #(
    parameter int DEPTH = 5120
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  srfc_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output srfc_pkg::t_result o_res
);
    import srfc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_back_state      r_state, n_state;
    logic             r_out_valid;
    t_result          r_res;
    logic [IDX_W-1:0] r_base, r_col, r_col_start, r_col_end;
    logic [4:0]       r_rows;
    logic [8:0]       r_pitch;
    logic [15:0]      r_color;

    logic             slot_free, last_col;
    logic             rd_en, ram_we;
    logic             load_emit, load_pix, load_strip;
    logic [IDX_W-1:0] idx;
    logic [15:0]      rdata;

    assign slot_free = !r_out_valid || i_out_ready;
    assign idx       = r_base + r_col;
    assign last_col  = ((r_col + 1'b1) == r_col_end);
    assign ram_we    = (r_state == BK_WRITE) && (32'(idx) < 32'(DEPTH));

    srfc_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(idx)),
        .i_wdata (r_color),
        .i_re    (rd_en),
        .i_raddr (AW'(i_job.pix)),
        .o_rdata (rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    case (i_job.kind)
                        JOB_WRITE: n_state = BK_WRITE;
                        JOB_READ:  n_state = BK_READ;
                        default:   ;
                    endcase
                end
            end
            BK_WRITE: if (last_col && (r_rows == 5'd1)) n_state = BK_DONE;
            BK_READ:  if (slot_free) n_state = BK_IDLE;
            BK_DONE:  if (slot_free) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop      = 1'b0;
        rd_en      = 1'b0;
        load_emit  = 1'b0;
        load_pix   = 1'b0;
        load_strip = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    case (i_job.kind)
                        JOB_EMIT: begin
                            o_pop     = slot_free;
                            load_emit = slot_free;
                        end
                        JOB_READ: begin
                            o_pop = 1'b1;
                            rd_en = 1'b1;
                        end
                        JOB_WRITE: o_pop = 1'b1;
                        default:   ;
                    endcase
                end
            end
            BK_READ: load_pix   = slot_free;
            BK_DONE: load_strip = slot_free;
            default: ;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_out_valid && !i_out_ready) || load_emit || load_pix || load_strip;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load_emit) begin
            r_res <= i_job.res;
        end else if (load_pix) begin
            r_res       <= '0;
            r_res.kind  <= RES_PIXEL;
            r_res.color <= rdata;
        end else if (load_strip) begin
            r_res      <= '0;
            r_res.kind <= RES_STRIP;
        end
    end

    // raster walk over the covered strip entries
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_job.kind == JOB_WRITE)) begin
            r_base      <= i_job.base;
            r_col       <= i_job.col_start;
            r_col_start <= i_job.col_start;
            r_col_end   <= i_job.col_end;
            r_rows      <= i_job.rows;
            r_pitch     <= i_job.pitch;
            r_color     <= i_job.color;
        end else if (r_state == BK_WRITE) begin
            if (last_col) begin
                r_base <= r_base + IDX_W'(r_pitch);
                r_col  <= r_col_start;
                r_rows <= r_rows - 5'd1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    `SRFC_ASSERT_IMP(a_we_only_walking, ram_we, r_state == BK_WRITE)
    `SRFC_ASSERT_IMP(a_we_in_store, ram_we, 32'(idx) < 32'(DEPTH))
    `SRFC_ASSERT_IMP(a_rows_live, r_state == BK_WRITE, r_rows != 5'd0)
    `SRFC_ASSERT_NXT(a_read_waits, rd_en, r_state == BK_READ)

endmodule

[hw/rtl/strip_rect_fill_compositor.sv]
// Channel  Dir  Handshake                 Payload
// -------  ---  ------------------------  ---------------------------------------------
// in       in   i_in_valid / o_in_ready   opcode, rect_x/y/width/height, color, index
// out      out  o_out_valid / i_out_ready result_kind, out_x/y/width/height, color
// cfg      in   i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// The front clips and classifies an item in its accept cycle and queues it (2 deep).
// The back takes one item at a time: a result needing no store access goes to its
// output register, a pixel read reads the strip store, and a compose fill or clear
// writes the covered area, or min(columns * rows, depth) entries, via one write port.
// Reset clears control state only; the strip store holds no reset and needs no pass.
// A stalled output holds its item; the queue keeps accepting until it is full.
module strip_rect_fill_compositor #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int STRIP_ROWS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [15:0] i_rect_x,
    input  logic signed [15:0] i_rect_y,
    input  logic signed [15:0] i_rect_width,
    input  logic signed [15:0] i_rect_height,
    input  logic [15:0]        i_fill_color,
    input  logic [12:0]        i_pixel_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_result_kind,
    output logic [8:0]         o_out_x,
    output logic [7:0]         o_out_y,
    output logic [8:0]         o_out_width,
    output logic [7:0]         o_out_height,
    output logic [15:0]        o_out_color
);
    import srfc_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * STRIP_ROWS;

    t_job    push_job, head_job;
    t_result res;
    logic    push, pop, q_full, q_empty;

    srfc_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .DEPTH         (DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_rect_x      (i_rect_x),
        .i_rect_y      (i_rect_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_fill_color  (i_fill_color),
        .i_pixel_index (i_pixel_index),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    srfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    srfc_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_result_kind = res.kind;
    assign o_out_x       = res.x;
    assign o_out_y       = res.y;
    assign o_out_width   = res.width;
    assign o_out_height  = res.height;
    assign o_out_color   = res.color;

endmodule
